FILE: rtl/pvz_pkg.sv
// Package with the shared types and constants of the per-voxel z-score block.
`timescale 1ns / 1ps

package pvz_pkg;

   localparam int MAX_IMAGES  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 7;
   localparam int ADDR_BITS   = 6;
   localparam int SUM_BITS    = 22;
   localparam int SQSUM_BITS  = 38;

   localparam logic [1:0] CSR_IMAGE_COUNT    = 2'd0;
   localparam logic [1:0] CSR_MEAN_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_ABSOLUTE_MODE  = 2'd2;

   localparam logic [6:0] IMAGE_COUNT_RESET = 7'd8;

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic               voxel_last;
   } req_type;

   typedef struct packed {
      logic signed [15:0] zscore;
      logic               masked;
      logic               run_last;
   } rsp_type;

endpackage

FILE: rtl/per_voxel_zscore_masked_top.sv
// Top level of the per-voxel z-score block with masking.
//
// Samples of one voxel arrive on the req_ channel, one transfer per image,
// taken when start is high and busy is low. Each sample keeps the block
// busy through the accumulate state while its square is accumulated. A voxel
// closes on the sample flagged voxel_last or when the configured image
// count, clamped to 2..64, is reached. The block then runs its statistics
// through the shared multiplier and gives one score per gathered sample,
// in input order, on the rsp_ channel, each for exactly one cycle marked
// by rsp_valid. A masked voxel gives zero scores without the root unit;
// otherwise each score is set by the restoring divider (33 steps) and the
// square root (17 steps) of the root unit, or the square root alone when
// the quotient saturates. The receiver cannot stall the channel.
// Configuration is written through the csr_ channel, which is always ready,
// and is meant to change only while the block is idle.
// Synchronous reset empties the current voxel and restores the register
// defaults; the sample store is not cleared.
`timescale 1ns / 1ps

module per_voxel_zscore_masked_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pvz_pkg::req_type req_data,
   output logic             rsp_valid,
   output pvz_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   typedef enum logic [14:0] {
      S_IDLE = 15'b000000000000001,
      S_ACC  = 15'b000000000000010,
      S_NQ   = 15'b000000000000100,
      S_S2   = 15'b000000000001000,
      S_MEAN = 15'b000000000010000,
      S_DEN  = 15'b000000000100000,
      S_DENC = 15'b000000001000000,
      S_RD   = 15'b000000010000000,
      S_MX   = 15'b000000100000000,
      S_DF   = 15'b000001000000000,
      S_D2   = 15'b000010000000000,
      S_R    = 15'b000100000000000,
      S_GO   = 15'b001000000000000,
      S_WAIT = 15'b010000000000000,
      S_OUT  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]         image_count_ff;
   logic signed [15:0] threshold_ff;
   logic               absolute_ff;

   logic signed [15:0] mem [pvz_pkg::MAX_IMAGES];
   logic signed [15:0] rd_ff;

   logic signed [21:0] sum_ff, sum_in;
   logic [37:0]        sq_ff, sq_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [6:0]         k_ff, k_in;
   logic               last_ff;
   logic signed [15:0] x_ff;

   logic signed [44:0] mul_a;
   logic signed [23:0] mul_b;
   logic signed [68:0] prod_ff;

   logic [42:0]        nq_ff, nq_in;
   logic [42:0]        dev2_ff, dev2_in;
   logic [48:0]        den_ff, den_in;
   logic               masked_ff, masked_in;
   logic signed [23:0] diff_ff, diff_in;
   logic [22:0]        diff_mag;
   logic [7:0]         limit;
   logic               root_start;
   logic               root_done;
   logic [16:0]        root_val;
   logic [15:0]        zval;
   logic               rsp_valid_ff, rsp_valid_in;
   pvz_pkg::rsp_type   rsp_ff, rsp_in;

   always_comb begin
      if (image_count_ff < 7'd2) begin
         limit = 8'd2;
      end else if ({1'b0, image_count_ff} > 8'(pvz_pkg::MAX_IMAGES)) begin
         limit = 8'(pvz_pkg::MAX_IMAGES);
      end else begin
         limit = {1'b0, image_count_ff};
      end
   end

   assign diff_mag = diff_ff[23] ? 23'(-diff_ff) : diff_ff[22:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_IDLE: begin
            mul_a = 45'(req_data.sample_value);
            mul_b = 24'(req_data.sample_value);
         end
         S_NQ: begin
            mul_a = $signed({7'd0, sq_ff});
            mul_b = $signed({17'd0, cnt_ff});
         end
         S_S2: begin
            mul_a = 45'(sum_ff);
            mul_b = 24'(sum_ff);
         end
         S_MEAN: begin
            mul_a = 45'(threshold_ff);
            mul_b = $signed({17'd0, cnt_ff});
         end
         S_DEN: begin
            mul_a = $signed({2'd0, dev2_ff});
            mul_b = $signed({17'd0, cnt_ff});
         end
         S_MX: begin
            mul_a = 45'(rd_ff);
            mul_b = $signed({17'd0, cnt_ff});
         end
         S_D2: begin
            mul_a = $signed({22'd0, diff_mag});
            mul_b = $signed({1'b0, diff_mag});
         end
         S_R: begin
            mul_a = $signed({1'b0, prod_ff[43:0]});
            mul_b = $signed({17'd0, cnt_ff - 7'd1});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      if (masked_ff) begin
         zval = '0;
      end else if (diff_ff[23] && !absolute_ff) begin
         zval = (root_val > 17'd32768) ? 16'h8000 : 16'(-root_val);
      end else begin
         zval = (root_val > 17'd32767) ? 16'h7FFF : root_val[15:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      nq_in        = nq_ff;
      dev2_in      = dev2_ff;
      den_in       = den_ff;
      masked_in    = masked_ff;
      diff_in      = diff_ff;
      root_start   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            sum_in = sum_ff + 22'(x_ff);
            sq_in  = sq_ff + {7'd0, prod_ff[30:0]};
            cnt_in = cnt_ff + 7'd1;
            if (last_ff || ({1'b0, cnt_ff} + 8'd1 >= limit)) begin
               state_in = S_NQ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_NQ: state_in = S_S2;
         S_S2: begin
            nq_in    = prod_ff[42:0];
            state_in = S_MEAN;
         end
         S_MEAN: begin
            dev2_in  = (nq_ff > prod_ff[42:0]) ? nq_ff - prod_ff[42:0] : '0;
            state_in = S_DEN;
         end
         S_DEN: begin
            masked_in = (dev2_ff == '0) || (69'(sum_ff) < prod_ff);
            state_in  = S_DENC;
         end
         S_DENC: begin
            den_in   = prod_ff[48:0];
            k_in     = '0;
            state_in = S_RD;
         end
         S_RD: state_in = masked_ff ? S_OUT : S_MX;
         S_MX: state_in = S_DF;
         S_DF: begin
            diff_in  = prod_ff[23:0] - 24'(sum_ff);
            state_in = S_D2;
         end
         S_D2: state_in = S_R;
         S_R:  state_in = S_GO;
         S_GO: begin
            root_start = 1'b1;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            if (root_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid_in    = 1'b1;
            rsp_in.zscore   = zval;
            rsp_in.masked   = masked_ff;
            rsp_in.run_last = (k_ff + 7'd1 == cnt_ff);
            k_in            = k_ff + 7'd1;
            if (k_ff + 7'd1 == cnt_ff) begin
               sum_in   = '0;
               sq_in    = '0;
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   pvz_root u_root (
      .clock     (clock),
      .reset     (reset),
      .start     (root_start),
      .ratio_num (prod_ff[49:0]),
      .ratio_den (den_ff),
      .done      (root_done),
      .root      (root_val)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         mem[cnt_ff[pvz_pkg::ADDR_BITS-1:0]] <= req_data.sample_value;
      end
      rd_ff <= mem[k_ff[pvz_pkg::ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         sum_ff         <= '0;
         sq_ff          <= '0;
         cnt_ff         <= '0;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         image_count_ff <= pvz_pkg::IMAGE_COUNT_RESET;
         threshold_ff   <= '0;
         absolute_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               pvz_pkg::CSR_IMAGE_COUNT:    image_count_ff <= csr_data[6:0];
               pvz_pkg::CSR_MEAN_THRESHOLD: threshold_ff   <= csr_data;
               pvz_pkg::CSR_ABSOLUTE_MODE:  absolute_ff    <= csr_data[0];
               default: ;
            endcase
         end
      end
      prod_ff   <= mul_a * mul_b;
      nq_ff     <= nq_in;
      dev2_ff   <= dev2_in;
      den_ff    <= den_in;
      masked_ff <= masked_in;
      diff_ff   <= diff_in;
      rsp_ff    <= rsp_in;
      if (state_ff == S_IDLE && start) begin
         x_ff    <= req_data.sample_value;
         last_ff <= req_data.voxel_last;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/pvz_root.sv
// Iterative unit giving the integer square root of a quotient of two wide integers, the numerator scaled by 2^22.
`timescale 1ns / 1ps

module pvz_root (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [49:0] ratio_num,
   input  logic [48:0] ratio_den,
   output logic        done,
   output logic [16:0] root
);

   typedef enum logic [2:0] {
      R_IDLE = 3'b001,
      R_DIV  = 3'b010,
      R_SQ   = 3'b100
   } root_state_type;

   root_state_type state_ff, state_in;
   logic [71:0] rem_ff, rem_in;
   logic [80:0] dsh_ff, dsh_in;
   logic [32:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [33:0] sq_ff, sq_in;
   logic [19:0] srem_ff, srem_in;
   logic [16:0] root_ff, root_in;
   logic        done_ff, done_in;

   logic [71:0] num;
   logic        sat;
   logic        div_ge;
   logic [19:0] cur;
   logic [19:0] trial;
   logic        sq_ge;

   assign num    = {ratio_num, 22'd0};
   assign sat    = {10'd0, num} >= {ratio_den, 33'd0};
   assign div_ge = {9'd0, rem_ff} >= dsh_ff;
   assign cur    = {srem_ff[17:0], sq_ff[33:32]};
   assign trial  = {1'b0, root_ff[16:0], 2'b01};
   assign sq_ge  = cur >= trial;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      sq_in    = sq_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               srem_in = '0;
               root_in = '0;
               if (sat) begin
                  sq_in    = {1'b0, {33{1'b1}}};
                  cnt_in   = 6'd16;
                  state_in = R_SQ;
               end else begin
                  rem_in   = num;
                  dsh_in   = {ratio_den, 32'd0};
                  q_in     = '0;
                  cnt_in   = 6'd32;
                  state_in = R_DIV;
               end
            end
         end
         R_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dsh_ff[71:0];
            end
            q_in   = {q_ff[31:0], div_ge};
            dsh_in = {1'b0, dsh_ff[80:1]};
            if (cnt_ff == 6'd0) begin
               sq_in    = {1'b0, q_ff[31:0], div_ge};
               cnt_in   = 6'd16;
               state_in = R_SQ;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         R_SQ: begin
            srem_in = sq_ge ? cur - trial : cur;
            root_in = {root_ff[15:0], sq_ge};
            sq_in   = {sq_ff[31:0], 2'b00};
            if (cnt_ff == 6'd0) begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      sq_ff   <= sq_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: rtl/pvz_checker.sv
// Port-level checker for the per-voxel z-score block and its bind statement.
`timescale 1ns / 1ps

module pvz_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input pvz_pkg::rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after an accepted transfer");

   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("scores on back-to-back cycles");

   a_masked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.masked |-> rsp_data.zscore == 16'sd0)
      else $error("masked score is not zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("activity straight after reset");

endmodule

bind per_voxel_zscore_masked_top pvz_checker u_pvz_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
